// File: rtl/pksc_pkg.sv
// Shared constants, types and tables of the password keyed stream cipher.
package pksc_pkg;

  localparam int unsigned STRETCH_ROUNDS = 20000;
  localparam int unsigned SR_W = 15;

  typedef enum logic [1:0] {
    F_PASS  = 2'd0,
    F_EMPTY = 2'd1,
    F_TEXT  = 2'd2,
    F_NONE  = 2'd3
  } func_e;

  typedef struct packed {
    logic init;
    logic absorb;
    logic pad_start;
    logic stretch_clr;
    logic stretch_go;
    logic key_load;
    logic encrypt;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic pad_done;
    logic stretch_end;
    logic key_ready;
  } stat_t;

  localparam logic [255:0] IV256 = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [511:0] IV512 = {
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

  localparam logic [31:0] K256 [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,32'h923f82a4,
    32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,32'h72be5d74,32'h80deb1fe,
    32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,
    32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,
    32'hc6e00bf3,32'hd5a79147,32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,
    32'h53380d13,32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,32'h19a4c116,
    32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,32'h5b9cca4f,32'h682e6ff3,
    32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,32'h90befffa,32'ha4506ceb,32'hbef9a3f7,
    32'hc67178f2};

  localparam logic [63:0] K512 [80] = '{
    64'h428a2f98d728ae22,64'h7137449123ef65cd,64'hb5c0fbcfec4d3b2f,64'he9b5dba58189dbbc,
    64'h3956c25bf348b538,64'h59f111f1b605d019,64'h923f82a4af194f9b,64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242,64'h12835b0145706fbe,64'h243185be4ee4b28c,64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f,64'h80deb1fe3b1696b1,64'h9bdc06a725c71235,64'hc19bf174cf692694,
    64'he49b69c19ef14ad2,64'hefbe4786384f25e3,64'h0fc19dc68b8cd5b5,64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275,64'h4a7484aa6ea6e483,64'h5cb0a9dcbd41fbd4,64'h76f988da831153b5,
    64'h983e5152ee66dfab,64'ha831c66d2db43210,64'hb00327c898fb213f,64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2,64'hd5a79147930aa725,64'h06ca6351e003826f,64'h142929670a0e6e70,
    64'h27b70a8546d22ffc,64'h2e1b21385c26c926,64'h4d2c6dfc5ac42aed,64'h53380d139d95b3df,
    64'h650a73548baf63de,64'h766a0abb3c77b2a8,64'h81c2c92e47edaee6,64'h92722c851482353b,
    64'ha2bfe8a14cf10364,64'ha81a664bbc423001,64'hc24b8b70d0f89791,64'hc76c51a30654be30,
    64'hd192e819d6ef5218,64'hd69906245565a910,64'hf40e35855771202a,64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8,64'h1e376c085141ab53,64'h2748774cdf8eeb99,64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63,64'h4ed8aa4ae3418acb,64'h5b9cca4f7763e373,64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc,64'h78a5636f43172f60,64'h84c87814a1f0ab72,64'h8cc702081a6439ec,
    64'h90befffa23631e28,64'ha4506cebde82bde9,64'hbef9a3f7b2c67915,64'hc67178f2e372532b,
    64'hca273eceea26619c,64'hd186b8c721c0c207,64'heada7dd6cde0eb1e,64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba,64'h0a637dc5a2c898a6,64'h113f9804bef90dae,64'h1b710b35131c471b,
    64'h28db77f523047d84,64'h32caab7b40c72493,64'h3c9ebe0a15c9bebc,64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6,64'h597f299cfc657e2a,64'h5fcb6fab3ad6faec,64'h6c44198c4a475817};

endpackage

// File: rtl/pksc_sha256.sv
// Iterative SHA-256 compression unit, one round per cycle.
module pksc_sha256 import pksc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [511:0] blk_i,
  input  logic [255:0] h_i,
  output logic         busy_o,
  output logic         done_o,
  output logic [255:0] h_o
);

  function automatic logic [31:0] rr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] v_q [8];
  logic [31:0] hb_q [8];
  logic [31:0] w_q [16];
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [31:0] t1, t2, wn;

  always_comb begin
    t1 = v_q[7] + (rr(v_q[4], 6) ^ rr(v_q[4], 11) ^ rr(v_q[4], 25)) +
         ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + K256[cnt_q] + w_q[0];
    t2 = (rr(v_q[0], 2) ^ rr(v_q[0], 13) ^ rr(v_q[0], 22)) +
         ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
    wn = w_q[0] + (rr(w_q[1], 7) ^ rr(w_q[1], 18) ^ (w_q[1] >> 3)) + w_q[9] +
         (rr(w_q[14], 17) ^ rr(w_q[14], 19) ^ (w_q[14] >> 10));
    for (int i = 0; i < 8; i++) begin
      h_o[255-32*i -: 32] = hb_q[i] + v_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 6'd63);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      for (int i = 0; i < 8; i++) begin
        v_q[i]  <= h_i[255-32*i -: 32];
        hb_q[i] <= h_i[255-32*i -: 32];
      end
      for (int i = 0; i < 16; i++) w_q[i] <= blk_i[511-32*i -: 32];
    end else if (busy_q) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wn;
    end
  end

  assign busy_o = busy_q | done_q;
  assign done_o = done_q;

endmodule

// File: rtl/pksc_sha512.sv
// Iterative SHA-512 compression unit, one round per cycle.
module pksc_sha512 import pksc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [1023:0] blk_i,
  input  logic [511:0]  h_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [511:0]  h_o
);

  function automatic logic [63:0] rr(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  logic [63:0] v_q [8];
  logic [63:0] hb_q [8];
  logic [63:0] w_q [16];
  logic [6:0]  cnt_q;
  logic        busy_q, done_q;
  logic [63:0] t1, t2, wn;

  always_comb begin
    t1 = v_q[7] + (rr(v_q[4], 14) ^ rr(v_q[4], 18) ^ rr(v_q[4], 41)) +
         ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + K512[cnt_q] + w_q[0];
    t2 = (rr(v_q[0], 28) ^ rr(v_q[0], 34) ^ rr(v_q[0], 39)) +
         ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
    wn = w_q[0] + (rr(w_q[1], 1) ^ rr(w_q[1], 8) ^ (w_q[1] >> 7)) + w_q[9] +
         (rr(w_q[14], 19) ^ rr(w_q[14], 61) ^ (w_q[14] >> 6));
    for (int i = 0; i < 8; i++) begin
      h_o[511-64*i -: 64] = hb_q[i] + v_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 7'd79);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd79) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      for (int i = 0; i < 8; i++) begin
        v_q[i]  <= h_i[511-64*i -: 64];
        hb_q[i] <= h_i[511-64*i -: 64];
      end
      for (int i = 0; i < 16; i++) w_q[i] <= blk_i[1023-64*i -: 64];
    end else if (busy_q) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wn;
    end
  end

  assign busy_o = busy_q | done_q;
  assign done_o = done_q;

endmodule

// File: rtl/pksc_dp.sv
// Datapath: block buffers, padding, hash state, stretching and key window.
module pksc_dp import pksc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_i,
  output stat_t      stat_o,
  output logic [7:0] cipher_byte_o,
  output logic       status_o
);

  typedef enum logic [1:0] {
    P_MARK  = 2'd0,
    P_ZFILL = 2'd1,
    P_BODY  = 2'd2,
    P_DONE  = 2'd3
  } pad_e;

  logic [511:0]  blk256_q, win_q, seed_q, hs512_q, key_seed;
  logic [1023:0] blk512_q;
  logic [255:0]  hs256_q, h256, h512_lo;
  logic [511:0]  h512;
  logic [63:0]   len_q;
  logic [5:0]    pos256_q;
  logic [6:0]    pos512_q;
  pad_e          ph256_q, ph512_q;
  logic          go256_q, go512_q, key_ready_q;
  logic [SR_W-1:0] scnt_q;
  logic [7:0]    cipher_q;
  logic          status_q;

  logic          busy256, busy512, c256_busy, c512_busy, c256_done, c512_done;
  logic          pad256, pad512, push256, push512;
  logic [7:0]    byte256, byte512, pb256, pb512, kbyte;
  logic [63:0]   bits256;
  logic [127:0]  bits512;
  logic [511:0]  sblk, c256_blk;
  logic [255:0]  c256_h;
  logic          c256_start;

  assign busy256 = go256_q | c256_busy;
  assign busy512 = go512_q | c512_busy;
  assign pad256  = (ph256_q != P_DONE) && !busy256;
  assign pad512  = (ph512_q != P_DONE) && !busy512;
  assign push256 = cmd_i.absorb | pad256;
  assign push512 = cmd_i.absorb | pad512;
  assign bits256 = {len_q[60:0], 3'b000};
  assign bits512 = {61'd0, len_q, 3'b000};
  assign h512_lo = '0;

  always_comb begin
    case (ph256_q)
      P_MARK:  pb256 = 8'h80;
      P_BODY:  pb256 = (pos256_q >= 6'd56) ? bits256[8*(7-pos256_q[2:0]) +: 8] : 8'h00;
      default: pb256 = 8'h00;
    endcase
    case (ph512_q)
      P_MARK:  pb512 = 8'h80;
      P_BODY:  pb512 = (pos512_q >= 7'd112) ? bits512[8*(15-pos512_q[3:0]) +: 8] : 8'h00;
      default: pb512 = 8'h00;
    endcase
    byte256 = cmd_i.absorb ? data_byte_i : pb256;
    byte512 = cmd_i.absorb ? data_byte_i : pb512;
  end

  assign sblk       = {hs256_q, 32'h80000000, 160'd0, 64'd256};
  assign c256_start = go256_q | cmd_i.stretch_go;
  assign c256_blk   = cmd_i.stretch_go ? sblk : blk256_q;
  assign c256_h     = cmd_i.stretch_go ? IV256 : hs256_q;
  assign key_seed   = hs512_q ^ {hs256_q, hs256_q};
  assign kbyte      = win_q[511 -: 8] ^ win_q[495 -: 8] ^ win_q[471 -: 8] ^ win_q[463 -: 8];

  pksc_sha256 u_sha256 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (c256_start),
    .blk_i   (c256_blk),
    .h_i     (c256_h),
    .busy_o  (c256_busy),
    .done_o  (c256_done),
    .h_o     (h256)
  );

  pksc_sha512 u_sha512 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (go512_q),
    .blk_i   (blk512_q),
    .h_i     (hs512_q),
    .busy_o  (c512_busy),
    .done_o  (c512_done),
    .h_o     (h512)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hs256_q     <= IV256;
      hs512_q     <= IV512;
      len_q       <= '0;
      pos256_q    <= '0;
      pos512_q    <= '0;
      ph256_q     <= P_DONE;
      ph512_q     <= P_DONE;
      go256_q     <= 1'b0;
      go512_q     <= 1'b0;
      key_ready_q <= 1'b0;
      scnt_q      <= '0;
    end else begin
      go256_q <= push256 && (pos256_q == 6'd63);
      go512_q <= push512 && (pos512_q == 7'd127);
      if (cmd_i.init) begin
        hs256_q     <= IV256;
        hs512_q     <= IV512;
        key_ready_q <= 1'b0;
        len_q       <= {63'd0, cmd_i.absorb};
        pos256_q    <= {5'd0, cmd_i.absorb};
        pos512_q    <= {6'd0, cmd_i.absorb};
      end else begin
        if (cmd_i.absorb) len_q <= len_q + 64'd1;
        if (push256) pos256_q <= pos256_q + 6'd1;
        if (push512) pos512_q <= pos512_q + 7'd1;
        if (c256_done) hs256_q <= h256;
        if (c512_done) hs512_q <= h512 ^ {h512_lo, h512_lo};
      end
      if (cmd_i.pad_start) begin
        ph256_q <= P_MARK;
        ph512_q <= P_MARK;
      end else begin
        if (pad256) begin
          case (ph256_q)
            P_MARK:  ph256_q <= ((pos256_q >= 6'd56) && (pos256_q != 6'd63)) ? P_ZFILL : P_BODY;
            P_ZFILL: if (pos256_q == 6'd63) ph256_q <= P_BODY;
            P_BODY:  if (pos256_q == 6'd63) ph256_q <= P_DONE;
            default: ph256_q <= P_DONE;
          endcase
        end
        if (pad512) begin
          case (ph512_q)
            P_MARK:  ph512_q <= ((pos512_q >= 7'd112) && (pos512_q != 7'd127)) ? P_ZFILL : P_BODY;
            P_ZFILL: if (pos512_q == 7'd127) ph512_q <= P_BODY;
            P_BODY:  if (pos512_q == 7'd127) ph512_q <= P_DONE;
            default: ph512_q <= P_DONE;
          endcase
        end
      end
      if (cmd_i.stretch_clr) scnt_q <= '0;
      else if (cmd_i.stretch_go) scnt_q <= scnt_q + 1'b1;
      if (cmd_i.key_load) key_ready_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push256) blk256_q <= {blk256_q[503:0], byte256};
    if (push512) blk512_q <= {blk512_q[1015:0], byte512};
    if (cmd_i.key_load) begin
      seed_q <= key_seed;
      win_q  <= key_seed;
    end else if (cmd_i.encrypt && key_ready_q) begin
      win_q <= last_i ? seed_q : {win_q[503:0], kbyte};
    end
    if (cmd_i.encrypt) begin
      cipher_q <= key_ready_q ? (data_byte_i ^ kbyte) : 8'h00;
      status_q <= !key_ready_q;
    end
  end

  always_comb begin
    stat_o.busy        = busy256 | busy512;
    stat_o.pad_done    = (ph256_q == P_DONE) && (ph512_q == P_DONE) && !busy256 && !busy512;
    stat_o.stretch_end = (scnt_q == SR_W'(STRETCH_ROUNDS));
    stat_o.key_ready   = key_ready_q;
  end

  assign cipher_byte_o = cipher_q;
  assign status_o      = status_q;

endmodule

// File: rtl/pksc_ctrl.sv
// Controller: request handshakes and key derivation sequencing.
module pksc_ctrl import pksc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] func_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  stat_t      stat_i,
  output cmd_t       cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_WAIT    = 5'b00010,
    S_PAD     = 5'b00100,
    S_STRETCH = 5'b01000,
    S_KEY     = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   open_q, open_d, last_q, last_d, oval_q, oval_d, acc;

  assign in_ready_o  = (state_q == S_IDLE) && (!oval_q || out_ready_i);
  assign acc         = in_valid_i && in_ready_o;
  assign out_valid_o = oval_q;

  always_comb begin
    state_d = state_q;
    open_d  = open_q;
    last_d  = last_q;
    oval_d  = oval_q && !out_ready_i;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (func_e'(func_i))
            F_PASS: begin
              cmd_o.init   = !open_q;
              cmd_o.absorb = 1'b1;
              open_d       = 1'b1;
              last_d       = last_i;
              state_d      = S_WAIT;
            end
            F_EMPTY: begin
              cmd_o.init      = 1'b1;
              cmd_o.pad_start = 1'b1;
              open_d          = 1'b1;
              state_d         = S_PAD;
            end
            F_TEXT: begin
              cmd_o.encrypt = 1'b1;
              oval_d        = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_WAIT: begin
        if (!stat_i.busy) begin
          if (last_q) begin
            cmd_o.pad_start = 1'b1;
            state_d         = S_PAD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_PAD: begin
        if (stat_i.pad_done) begin
          cmd_o.stretch_clr = 1'b1;
          state_d           = S_STRETCH;
        end
      end
      S_STRETCH: begin
        if (!stat_i.busy) begin
          if (stat_i.stretch_end) state_d = S_KEY;
          else cmd_o.stretch_go = 1'b1;
        end
      end
      S_KEY: begin
        cmd_o.key_load = 1'b1;
        open_d         = 1'b0;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      open_q  <= 1'b0;
      last_q  <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      open_q  <= open_d;
      last_q  <= last_d;
      oval_q  <= oval_d;
    end
  end

endmodule

// File: rtl/password_keyed_stream_cipher_core.sv
// Top level of the password keyed stream cipher.
// Password bytes are absorbed one per request; each full 64-byte block runs the SHA-256
// unit and each full 128-byte block runs the SHA-512 unit. The last password byte (or
// an empty-password request) starts key derivation: padding and final compressions,
// then 20000 chained SHA-256 compressions on the single iterative SHA-256 round unit.
// A plaintext byte is taken only when the previous cipher byte has been or is being
// taken at the output; a byte sent before a key exists returns status 1 and zero.
module password_keyed_stream_cipher_core import pksc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] func_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] cipher_byte_o,
  output logic       status_o
);

  cmd_t  cmd;
  stat_t stat;

  pksc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pksc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (data_byte_i),
    .last_i        (last_i),
    .stat_o        (stat),
    .cipher_byte_o (cipher_byte_o),
    .status_o      (status_o)
  );

endmodule
